// ===== rtl/core/ccd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared widths, reset values and the result-slot type of the circular
// central difference block.
// ----------------------------------------------------------------------------
package ccd_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int DIFF_W        = SAMPLE_W + 1;
	localparam int POS_W         = 10;
	localparam int MAX_LENGTH_DEF = 1024;
	localparam int SLOTS         = 3;
	localparam int SLOT_CNT_W    = 2;

	localparam logic signed [SAMPLE_W-1:0] GAIN_RESET = 16'sd256;

	// One pending result: the difference still to be scaled, its run index
	// and whether it closes the run.
	typedef struct packed {
		logic signed [DIFF_W-1:0] diff;
		logic [POS_W-1:0]         pos;
		logic                     fin;
	} slot_t;

endpackage

// ===== rtl/core/ccd_if.sv =====
// ----------------------------------------------------------------------------
// ccd_if
// Valid/ready channels of the circular central difference block: the sample
// stream in and the slope stream out.
// ----------------------------------------------------------------------------
interface ccd_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               run_end;

	modport source (output valid, output sample, output run_end, input ready);
	modport sink   (input valid, input sample, input run_end, output ready);
endinterface

interface ccd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] slope;
	logic [9:0]         position;
	logic               final_result;

	modport source (output valid, output slope, output position, output final_result,
		input ready);
	modport sink   (input valid, input slope, input position, input final_result,
		output ready);
endinterface

// ===== rtl/core/circular_central_difference.sv =====
// ----------------------------------------------------------------------------
// circular_central_difference
// Scaled central difference over a circular run of Q8.8 samples.
// ----------------------------------------------------------------------------
// Samples enter on the samples channel, one per transaction, with run_end
// on the last sample of a run; a sample that fills MAX_LENGTH also ends it.
// Each sample from the third one on yields the slope of the position before
// it. The last sample yields the slope of position n-2, then the wrapped
// position n-1, then position 0 with final_result set. Runs of one or two
// samples give zero slopes. Results leave on the slopes channel.
// The user writes the gain register through cfg_we/cfg_wdata only while
// the block is idle, a rule the block leaves to the user. It resets to 1.0.
// A result passes through the three-entry result queue and then the output
// register before it is presented. One sample is taken every cycle while the
// receiver does not stall; the last sample of a run occupies the single shared
// multiplier for each of its results, so the next run's first sample waits
// until the last of those results is leaving the queue.
// If the receiver stalls, the output register holds and the queue keeps its
// pending results; samples are taken only while the queue is empty or its
// last pending result is leaving. Reset empties the queue and the output,
// starts a new run and restores the gain; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_central_difference
	import ccd_pkg::*;
#(
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic signed [SAMPLE_W-1:0] cfg_wdata,
	ccd_in_if.sink                   samples,
	ccd_out_if.source                slopes
);

	localparam int CW   = $clog2(MAX_LENGTH);
	localparam int PW   = (CW > POS_W) ? CW : POS_W;
	localparam int PROD_W = SAMPLE_W + DIFF_W;

	logic signed [SAMPLE_W-1:0] gain_q;
	logic signed [SAMPLE_W-1:0] first_q, second_q, older_q, newer_q;
	logic [CW-1:0]              count_q;

	slot_t                 slot_s1 [SLOTS];
	logic [SLOT_CNT_W-1:0] num_s1;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] slope_q;
	logic [POS_W-1:0]           position_q;
	logic                       final_q;

	logic                       accept, advance, last;
	logic signed [SAMPLE_W-1:0] s, second_eff;
	slot_t                      new_slot [SLOTS];
	logic [SLOT_CNT_W-1:0]      new_num;
	logic [PW-1:0]              k_ext, km1_ext;

	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-10:0]  shifted;
	logic signed [SAMPLE_W-1:0] slope_d;

	assign advance = (num_s1 != '0) && (!out_valid_q || slopes.ready);
	assign samples.ready = (num_s1 == '0) || ((num_s1 == SLOT_CNT_W'(1)) && advance);
	assign accept = samples.valid && samples.ready;

	assign s          = samples.sample;
	assign last       = samples.run_end || (count_q == CW'(MAX_LENGTH - 1));
	assign second_eff = (count_q == CW'(1)) ? s : second_q;
	assign k_ext      = PW'(count_q);
	assign km1_ext    = PW'(count_q - CW'(1));

	// Build the results this sample causes, packed from the front of the queue.
	always_comb begin
		slot_t a1, a2, a3;
		a1.diff = DIFF_W'(s) - DIFF_W'(older_q);
		a1.pos  = km1_ext[POS_W-1:0];
		a1.fin  = 1'b0;
		a2.diff = DIFF_W'(first_q) - DIFF_W'(newer_q);
		a2.pos  = k_ext[POS_W-1:0];
		a2.fin  = 1'b0;
		a3.diff = DIFF_W'(second_eff) - DIFF_W'(s);
		a3.pos  = '0;
		a3.fin  = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			new_slot[i] = '0;
		end
		new_num = '0;
		if (last) begin
			if (count_q == '0) begin
				new_slot[0].fin = 1'b1;
				new_num         = SLOT_CNT_W'(1);
			end else if (count_q == CW'(1)) begin
				new_slot[0] = a2;
				new_slot[1] = a3;
				new_num     = SLOT_CNT_W'(2);
			end else begin
				new_slot[0] = a1;
				new_slot[1] = a2;
				new_slot[2] = a3;
				new_num     = SLOT_CNT_W'(3);
			end
		end else if (count_q >= CW'(2)) begin
			new_slot[0] = a1;
			new_num     = SLOT_CNT_W'(1);
		end
	end

	// Scale the head of the queue; the arithmetic shift rounds toward minus
	// infinity, which halves the difference and returns to Q8.8.
	assign prod    = PROD_W'(gain_q) * PROD_W'(slot_s1[0].diff);
	assign shifted = prod[PROD_W-1:9];

	always_comb begin
		if (shifted > (PROD_W-9)'(32767)) begin
			slope_d = 16'sh7FFF;
		end else if (shifted < -(PROD_W-9)'(32768)) begin
			slope_d = -16'sh8000;
		end else begin
			slope_d = shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			first_q  <= '0;
			second_q <= '0;
			older_q  <= '0;
			newer_q  <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			if (accept) begin
				if (count_q == '0) begin
					first_q <= s;
				end
				if (count_q == CW'(1)) begin
					second_q <= s;
				end
				older_q <= newer_q;
				newer_q <= s;
				count_q <= last ? '0 : count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_s1 <= '0;
		end else if (accept && (new_num != '0)) begin
			num_s1 <= new_num;
		end else if (advance) begin
			num_s1 <= num_s1 - SLOT_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (new_num != '0)) begin
			slot_s1 <= new_slot;
		end else if (advance) begin
			for (int i = 0; i < SLOTS - 1; i++) begin
				slot_s1[i] <= slot_s1[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (slopes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slope_q    <= slope_d;
			position_q <= slot_s1[0].pos;
			final_q    <= slot_s1[0].fin;
		end
	end

	assign slopes.valid        = out_valid_q;
	assign slopes.slope        = slope_q;
	assign slopes.position     = position_q;
	assign slopes.final_result = final_q;

endmodule
